/* rtl/sssc_pkg.sv */
// Shared types and defaults for the stack sortability checker.
`timescale 1ns / 1ps

package sssc_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int NUMBER_BITS_DEF = 16;
  localparam int ITEM_BITS       = 16;
  localparam int OUT_BYTE_BITS   = 8;

  typedef struct packed {
    logic accept;
    logic pop;
    logic load_top;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic serve;
    logic can_pop;
    logic below;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/sssc_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module sssc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sssc_dpath.sv */
// Datapath: stack count, served run, cached stack top, and output register.
`timescale 1ns / 1ps

module sssc_dpath #(
  parameter int STACK_DEPTH = 1024,
  parameter int NUMBER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sssc_pkg::ITEM_BITS-1:0] item_number,
  input  sssc_pkg::dp_cmd_t             cmd,
  output sssc_pkg::dp_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          sortable
);

  import sssc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int UB = (NUMBER_BITS < ITEM_BITS) ? NUMBER_BITS : ITEM_BITS;

  logic [CW-1:0]          count;
  logic [NUMBER_BITS-1:0] last_served;
  logic                   overflowed;
  logic [NUMBER_BITS-1:0] top;

  logic [NUMBER_BITS-1:0] x;
  logic [NUMBER_BITS:0]   next_wanted;
  logic                   full;
  logic [CW-1:0]          count_minus2;
  logic                   push;
  logic [NUMBER_BITS-1:0] rdata;

  assign x            = NUMBER_BITS'(item_number[UB-1:0]);
  assign next_wanted  = {1'b0, last_served} + (NUMBER_BITS + 1)'(1);
  assign full         = (count == CW'(STACK_DEPTH));
  assign count_minus2 = count - CW'(2);

  assign status.serve    = ({1'b0, x} == next_wanted);
  assign status.can_pop  = (count != '0) && ({1'b0, top} == next_wanted);
  assign status.below    = (count >= CW'(2));
  assign status.out_free = !out_valid || out_ready;

  assign push = cmd.accept && !status.serve && !full;

  // The RAM is always read one below the cached top, so a pop has the new
  // top ready on the following cycle.
  sssc_ram #(
    .WIDTH(NUMBER_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push),
    .waddr(count[AW-1:0]),
    .wdata(x),
    .raddr(count_minus2[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      last_served <= '0;
      overflowed  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (status.serve) begin
          last_served <= x;
        end else if (!full) begin
          count <= count + CW'(1);
          top   <= x;
        end else begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.pop) begin
        count       <= count - CW'(1);
        last_served <= last_served + NUMBER_BITS'(1);
      end
      if (cmd.load_top) begin
        top <= rdata;
      end
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        sortable    <= (count == '0) && !overflowed;
        count       <= '0;
        last_served <= '0;
        overflowed  <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> status.can_pop)
    else $error("pop without a matching stack top");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0) && (last_served == '0) && !overflowed && out_valid)
    else $error("state not cleared after verdict");
`endif

endmodule

/* rtl/sssc_ctrl.sv */
// Controller state machine: accept, drain run, refill top, give verdict.
`timescale 1ns / 1ps

module sssc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  sssc_pkg::dp_status_t status,
  output sssc_pkg::dp_cmd_t    cmd
);

  import sssc_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DRAIN,
    FETCH,
    VERDICT
  } state_t;

  state_t state;
  state_t state_next;
  logic   final_pend;
  logic   final_pend_next;

  always_comb begin
    state_next      = state;
    final_pend_next = final_pend;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept      = 1'b1;
          final_pend_next = in_last;
          if (status.serve || in_last) begin
            state_next = DRAIN;
          end
        end
      end
      DRAIN: begin
        if (status.can_pop) begin
          cmd.pop    = 1'b1;
          state_next = status.below ? FETCH : DRAIN;
        end else if (final_pend) begin
          state_next = VERDICT;
        end else begin
          state_next = IDLE;
        end
      end
      FETCH: begin
        cmd.load_top = 1'b1;
        state_next   = DRAIN;
      end
      VERDICT: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          final_pend_next = 1'b0;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      final_pend <= 1'b0;
    end else begin
      state      <= state_next;
      final_pend <= final_pend_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_verdict_final: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> final_pend)
    else $error("verdict given outside a final item");

  a_fetch_after_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.load_top |-> $past(cmd.pop))
    else $error("stack top refill without a pop");

  a_serve_drains: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.serve |=> state == DRAIN)
    else $error("served word not followed by a drain check");
`endif

endmodule

/* rtl/stack_sortable_sequence_check_unit.sv */
// Stack sortability checker: top level joining controller and datapath.
`timescale 1ns / 1ps

// Reads a sequence of item numbers, one word each, and tells on the word
// marked with tlast whether one side stack can deliver them in order 1, 2,
// 3 and so on. A word that is served at once, or is the last one, is
// followed by a drain check, and each entry popped from the stack, unless
// it was the bottom one, is followed by a refill of the cached top, since
// the stack lives in a RAM with a registered read. The verdict waits while
// the previous output word is still not taken. A new word is taken only in
// the idle state, not during a drain check, refill or verdict. Every number
// is pushed and popped at most once. No clearing pass is needed after reset.

module stack_sortable_sequence_check_unit #(
  parameter int STACK_DEPTH = sssc_pkg::STACK_DEPTH_DEF,
  parameter int NUMBER_BITS = sssc_pkg::NUMBER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sssc_pkg::ITEM_BITS-1:0]     s_tdata,  // [15:0] item_number
  input  logic                               s_tlast,  // last_item
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sssc_pkg::OUT_BYTE_BITS-1:0] m_tdata   // [0] sortable, rest zero
);

  import sssc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       sortable;

  sssc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_last (s_tlast),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  sssc_dpath #(
    .STACK_DEPTH(STACK_DEPTH),
    .NUMBER_BITS(NUMBER_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .item_number(s_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .sortable   (sortable)
  );

  assign m_tdata = {(OUT_BYTE_BITS - 1)'(0), sortable};

endmodule

/* dv/tb.sv */
// Self-checking testbench for the stack sortability checker.
`timescale 1ns / 1ps

module tb;

  import sssc_pkg::*;

  // A short stack and narrow numbers keep the full-stack and top-of-range
  // sequences short enough to run under every stall pattern.
  localparam int DEPTH    = 32;
  localparam int NUM_BITS = 8;
  localparam int MAX_NUM  = (1 << NUM_BITS) - 1;
  localparam int WORD_MAX = (1 << ITEM_BITS) - 1;

  typedef struct packed {
    logic [ITEM_BITS-1:0] num;
    logic                 last;
  } seq_word_t;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [ITEM_BITS-1:0]     s_tdata  = '0;  // [15:0] item_number
  logic                     s_tlast  = 1'b0;  // last_item
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_BYTE_BITS-1:0] m_tdata;  // [0] sortable, rest zero

  stack_sortable_sequence_check_unit #(
    .STACK_DEPTH(DEPTH),
    .NUMBER_BITS(NUM_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  seq_word_t pend_q[$];
  bit        verdict_q[$];
  int        perm_q[$];
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        err_cnt      = 0;
  int        word_cnt     = 0;
  int        verdict_cnt  = 0;

  // Shadow copy of the checker state.
  logic [NUM_BITS-1:0] shadow_stack [DEPTH];
  int                  shadow_count = 0;
  logic [NUM_BITS-1:0] shadow_served = '0;
  bit                  shadow_ovf = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // Pop every top that continues the served run; the increment is one bit wider.
  function automatic void pop_run();
    while (shadow_count > 0 &&
           {1'b0, shadow_stack[shadow_count-1]} == {1'b0, shadow_served} + 1'b1) begin
      shadow_count--;
      shadow_served = shadow_stack[shadow_count];
    end
  endfunction

  function automatic void predict_word(input seq_word_t w);
    logic [NUM_BITS-1:0] x;
    x = w.num[NUM_BITS-1:0];
    if ({1'b0, x} == {1'b0, shadow_served} + 1'b1) begin
      shadow_served = x;
      pop_run();
    end else if (shadow_count < DEPTH) begin
      shadow_stack[shadow_count] = x;
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (w.last) begin
      pop_run();
      verdict_q.insert(verdict_q.size(), shadow_count == 0 && !shadow_ovf);
      shadow_count  = 0;
      shadow_served = '0;
      shadow_ovf    = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : drive_p
    bit fire;
    fire = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        predict_word(pend_q[0]);
        void'(pend_q.pop_front());
        word_cnt++;
      end
      // A word on offer is held until it is taken.
      if (!(s_tvalid && !fire)) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pend_q[0].num;
          s_tlast  <= pend_q[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_p
    bit want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict 0x%02h with none pending", m_tdata));
        end else begin
          want = verdict_q.pop_front();
          verdict_cnt++;
          if (m_tdata !== {{(OUT_BYTE_BITS-1){1'b0}}, want})
            report_mismatch($sformatf("verdict 0x%02h, wanted sortable=%0d", m_tdata, want));
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic void add_word(input int num, input bit last);
    seq_word_t w;
    w.num  = num[ITEM_BITS-1:0];
    w.last = last;
    pend_q.insert(pend_q.size(), w);
  endfunction

  function automatic void add_perm();
    foreach (perm_q[i]) add_word(perm_q[i], i == perm_q.size() - 1);
  endfunction

  // A sequence is sortable when everything before its maximum is below
  // everything after it, recursively on both sides.
  function automatic void build_sortable(input int lo, input int hi);
    int k;
    if (lo > hi) return;
    k = $urandom_range(hi - 1, lo - 1);
    build_sortable(lo, k);
    perm_q.insert(perm_q.size(), hi);
    build_sortable(k + 1, hi - 1);
  endfunction

  function automatic int add_random_seq();
    int kind;
    int n;
    int a;
    int b;
    int t;
    kind = $urandom_range(99);
    n    = ($urandom_range(19) == 0) ? $urandom_range(200, 33) : $urandom_range(32, 1);
    perm_q.delete();
    if (kind < 88) begin
      if (kind < 55 || kind >= 75) begin
        build_sortable(1, n);
      end else begin
        for (int i = 1; i <= n; i++) perm_q.insert(perm_q.size(), i);
        for (int i = n - 1; i > 0; i--) begin
          a = $urandom_range(i);
          t = perm_q[i];
          perm_q[i] = perm_q[a];
          perm_q[a] = t;
        end
      end
      // Broken sortable sequence: two positions swapped.
      if (kind >= 75 && n > 1) begin
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        t = perm_q[a];
        perm_q[a] = perm_q[b];
        perm_q[b] = t;
      end
    end else begin
      // Full-width words, so the upper bits are dropped by the checker.
      for (int i = 0; i < n; i++)
        perm_q.insert(perm_q.size(),
                      ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(WORD_MAX));
    end
    add_perm();
    return n;
  endfunction

  initial begin : stim_p
    int phase_words;
    repeat (4) @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 84 : 0;
      snk_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 33 : 0;
      case (phase)
        0: begin
          add_word(1, 1'b1);
          add_word(2, 1'b1);
          add_word(0, 1'b1);
          add_word(MAX_NUM, 1'b1);
          add_word(3, 1'b0); add_word(1, 1'b0); add_word(2, 1'b1);
          add_word(2, 1'b0); add_word(3, 1'b0); add_word(1, 1'b1);
          add_word(1, 1'b0); add_word(2, 1'b0); add_word(3, 1'b1);
          add_word(0, 1'b0); add_word(1, 1'b1);
          add_word(1, 1'b0); add_word(1, 1'b1);
          for (int i = 5; i >= 1; i--) add_word(i, i == 1);
          // Stack filled to its last entry and then drained empty.
          for (int i = DEPTH + 1; i >= 1; i--) add_word(i, i == 1);
        end
        1: begin
          // Full stack, one dropped push, then a drain that empties it.
          for (int i = DEPTH + 1; i >= 2; i--) add_word(i, 1'b0);
          add_word(0, 1'b0);
          add_word(1, 1'b1);
        end
        default: begin
          // Serve every number up to the top of the range; nothing may follow.
          for (int i = 1; i <= MAX_NUM; i++) add_word(i, 1'b0);
          add_word(0, 1'b1);
        end
      endcase
      phase_words = 0;
      while (phase_words < 225) phase_words += add_random_seq();
      while (pend_q.size() != 0) @(negedge clk);
    end
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d words and checked %0d verdicts under three stall patterns,",
             word_cnt, verdict_cnt);
    $display("including full-stack, dropped-push and top-of-range sequences.");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
